FILE: design/glyph_text_pixel_renderer_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef GLYPH_TEXT_PIXEL_RENDERER_MACROS_SVH
`define GLYPH_TEXT_PIXEL_RENDERER_MACROS_SVH

// same-cycle implication
`define GTR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/gtr_pkg.sv
package gtr_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 128;

  localparam int ADDR_W  = 14;
  localparam int COLOR_W = 16;
  localparam int CODE_W  = 8;
  localparam int ORG_W   = 7;
  localparam int ROW_W   = 8;
  localparam int COL_W   = $clog2(SCREEN_WIDTH + 256);
  localparam int HCMP_W  = $clog2(SCREEN_HEIGHT + 256);
  localparam int IDX_W   = 7;
  localparam int POS_W   = 6;
  localparam int CX_W    = 3;
  localparam int CY_W    = 3;

  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_ROWS   = 7;
  localparam int CHAR_ADVANCE = 6;
  localparam int LINE_ADVANCE = 8;
  localparam int CELL_PIXELS  = (GLYPH_COLS + 1) * GLYPH_ROWS;

  localparam logic [CODE_W-1:0] CODE_END     = 8'd0;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] GLYPH_FIRST  = 8'd32;
  localparam logic [CODE_W-1:0] GLYPH_LAST   = 8'd126;
  localparam logic [CODE_W-1:0] GLYPH_SUBST  = 8'd63;

  localparam logic [ADDR_W-1:0] STEP_DOWN     = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] STEP_NEXT_COL =
    ADDR_W'(1 - (GLYPH_ROWS - 1) * SCREEN_WIDTH);

  typedef enum logic [1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1,
    CFG_FG_COLOR = 2'd2,
    CFG_BG_COLOR = 2'd3
  } gtr_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK
  } gtr_state_e;

  typedef struct packed {
    logic accept;
    logic start;
    logic end_str;
    logic newline;
    logic char_done;
  } gtr_cur_cmd_t;

  // five column bytes, column 0 in the low byte, bit 0 = top row
  function automatic logic [39:0] font_cols(input logic [IDX_W-1:0] idx);
    logic [39:0] c;
    unique case (idx)
      7'd0:  c = 40'h0000000000;
      7'd1:  c = 40'h00005F0000;
      7'd2:  c = 40'h0007000700;
      7'd3:  c = 40'h147F147F14;
      7'd4:  c = 40'h122A7F2A24;
      7'd5:  c = 40'h6264081323;
      7'd6:  c = 40'h5022554936;
      7'd7:  c = 40'h0000030500;
      7'd8:  c = 40'h0041221C00;
      7'd9:  c = 40'h001C224100;
      7'd10: c = 40'h14083E0814;
      7'd11: c = 40'h08083E0808;
      7'd12: c = 40'h0000305000;
      7'd13: c = 40'h0808080808;
      7'd14: c = 40'h0000606000;
      7'd15: c = 40'h0204081020;
      7'd16: c = 40'h3E4549513E;
      7'd17: c = 40'h00407F4200;
      7'd18: c = 40'h4649516142;
      7'd19: c = 40'h314B454121;
      7'd20: c = 40'h107F121418;
      7'd21: c = 40'h3945454527;
      7'd22: c = 40'h3049494A3C;
      7'd23: c = 40'h0305097101;
      7'd24: c = 40'h3649494936;
      7'd25: c = 40'h1E29494906;
      7'd26: c = 40'h0000363600;
      7'd27: c = 40'h0000365600;
      7'd28: c = 40'h0041221408;
      7'd29: c = 40'h1414141414;
      7'd30: c = 40'h0814224100;
      7'd31: c = 40'h0609510102;
      7'd32: c = 40'h3E41794932;
      7'd33: c = 40'h7E1111117E;
      7'd34: c = 40'h364949497F;
      7'd35: c = 40'h224141413E;
      7'd36: c = 40'h1C2241417F;
      7'd37: c = 40'h414949497F;
      7'd38: c = 40'h010909097F;
      7'd39: c = 40'h7A4949413E;
      7'd40: c = 40'h7F0808087F;
      7'd41: c = 40'h00417F4100;
      7'd42: c = 40'h013F414020;
      7'd43: c = 40'h412214087F;
      7'd44: c = 40'h404040407F;
      7'd45: c = 40'h7F0204027F;
      7'd46: c = 40'h7F1008047F;
      7'd47: c = 40'h3E4141413E;
      7'd48: c = 40'h060909097F;
      7'd49: c = 40'h5E2151413E;
      7'd50: c = 40'h462919097F;
      7'd51: c = 40'h3149494946;
      7'd52: c = 40'h01017F0101;
      7'd53: c = 40'h3F4040403F;
      7'd54: c = 40'h1F2040201F;
      7'd55: c = 40'h3F4038403F;
      7'd56: c = 40'h6314081463;
      7'd57: c = 40'h0708700807;
      7'd58: c = 40'h4345495161;
      7'd59: c = 40'h0041417F00;
      7'd60: c = 40'h2010080402;
      7'd61: c = 40'h007F414100;
      7'd62: c = 40'h0402010204;
      7'd63: c = 40'h4040404040;
      7'd64: c = 40'h0004020100;
      7'd65: c = 40'h7854545420;
      7'd66: c = 40'h384444487F;
      7'd67: c = 40'h2044444438;
      7'd68: c = 40'h7F48444438;
      7'd69: c = 40'h1854545438;
      7'd70: c = 40'h0201097E08;
      7'd71: c = 40'h3E5252520C;
      7'd72: c = 40'h780404087F;
      7'd73: c = 40'h00407D4400;
      7'd74: c = 40'h003D444020;
      7'd75: c = 40'h004428107F;
      7'd76: c = 40'h00407F4100;
      7'd77: c = 40'h780418047C;
      7'd78: c = 40'h780404087C;
      7'd79: c = 40'h3844444438;
      7'd80: c = 40'h081414147C;
      7'd81: c = 40'h7C18141408;
      7'd82: c = 40'h080404087C;
      7'd83: c = 40'h2054545448;
      7'd84: c = 40'h2040443F04;
      7'd85: c = 40'h7C2040403C;
      7'd86: c = 40'h1C2040201C;
      7'd87: c = 40'h3C4030403C;
      7'd88: c = 40'h4428102844;
      7'd89: c = 40'h3C5050500C;
      7'd90: c = 40'h444C546444;
      7'd91: c = 40'h0041360800;
      7'd92: c = 40'h00007F0000;
      7'd93: c = 40'h0008364100;
      7'd94: c = 40'h0810080408;
      default: c = 40'h0000000000;
    endcase
    return c;
  endfunction

  // cell bits in scan order: bit col*7+row; spacing column stays zero
  function automatic logic [CELL_PIXELS-1:0] font_cell(input logic [IDX_W-1:0] idx);
    logic [39:0]            cols;
    logic [CELL_PIXELS-1:0] g;
    cols = font_cols(idx);
    g    = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      g[c*GLYPH_ROWS +: GLYPH_ROWS] = cols[c*8 +: GLYPH_ROWS];
    end
    return g;
  endfunction

endpackage

FILE: design/gtr_cursor.sv
`include "glyph_text_pixel_renderer_macros.svh"

module gtr_cursor import gtr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gtr_cur_cmd_t      cmd_i,
  input  logic [ORG_W-1:0]  origin_x_i,
  input  logic [ORG_W-1:0]  origin_y_i,
  output logic [COL_W-1:0]  col_o,
  output logic [ROW_W-1:0]  row_o,
  output logic              stopped_o,
  output logic              eff_stopped_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             stopped_q, stopped_d;

  logic [COL_W-1:0] base_col;
  logic [ROW_W-1:0] base_row;
  logic             base_stop;
  logic [COL_W-1:0] col_adv;

  function automatic logic [ROW_W-1:0] line_down(input logic [ROW_W-1:0] r);
    logic [ROW_W:0] s;
    s = {1'b0, r} + (ROW_W+1)'(LINE_ADVANCE);
    return s[ROW_W] ? '1 : s[ROW_W-1:0];
  endfunction

  always_comb begin
    base_col  = cmd_i.start ? COL_W'(origin_x_i) : col_q;
    base_row  = cmd_i.start ? ROW_W'(origin_y_i) : row_q;
    base_stop = cmd_i.start ? 1'b0 : stopped_q;
    col_adv   = col_q + COL_W'(CHAR_ADVANCE);
    col_d     = col_q;
    row_d     = row_q;
    stopped_d = stopped_q;
    if (cmd_i.accept) begin
      col_d     = base_col;
      row_d     = base_row;
      stopped_d = base_stop;
      if (cmd_i.end_str) begin
        stopped_d = 1'b1;
      end
      if (cmd_i.newline) begin
        col_d = COL_W'(origin_x_i);
        row_d = line_down(base_row);
      end
    end else if (cmd_i.char_done) begin
      if (col_adv + COL_W'(CHAR_ADVANCE) >= COL_W'(SCREEN_WIDTH)) begin
        col_d = COL_W'(origin_x_i);
        row_d = line_down(row_q);
      end else begin
        col_d = col_adv;
      end
      if (HCMP_W'(row_d) + HCMP_W'(GLYPH_ROWS) >= HCMP_W'(SCREEN_HEIGHT)) begin
        stopped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      stopped_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      stopped_q <= stopped_d;
    end
  end

  assign col_o         = col_q;
  assign row_o         = row_q;
  assign stopped_o     = stopped_q;
  assign eff_stopped_o = base_stop;

  `GTR_ASSERT_NEXT(a_bottom_stop, cmd_i.char_done,
    stopped_q || (HCMP_W'(row_q) + HCMP_W'(GLYPH_ROWS) < HCMP_W'(SCREEN_HEIGHT)),
    "cursor left near bottom without stopping")
  `GTR_ASSERT_NEXT(a_col_on_screen, cmd_i.char_done,
    (col_q < COL_W'(SCREEN_WIDTH)) || (col_q == COL_W'(origin_x_i)),
    "cursor column past right edge")
  `GTR_ASSERT_NEXT(a_start_clears, cmd_i.accept && cmd_i.start && !cmd_i.end_str,
    !stopped_q, "start of string did not clear stop")

endmodule

FILE: design/glyph_text_pixel_renderer.sv
// Channel | Dir | Handshake             | Transaction payload
// --------+-----+-----------------------+--------------------------------------------
// in      | in  | in_valid_i/in_stall_o | char_code_i, start_of_string_i
// out     | out | out_valid_o/out_stall_i | pixel_address_o, pixel_color_o, last_pixel_o
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A drawn character keeps in_stall_o high after its transaction through the setup state
// (font lookup, base address) and the scan of the cell pixels through the shared address
// adder, one cell pixel per cycle while out_stall_i does not hold the output register, so
// a new character is not taken until the scan of the last one has finished.
// End of string, newline and stopped items finish in the accept cycle.
// in_stall_o is high from setup until the scan finishes; cfg is always ready.
// Reset puts the cursor at the origin reset value and clears the stop flag.
`include "glyph_text_pixel_renderer_macros.svh"

module glyph_text_pixel_renderer import gtr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CODE_W-1:0]  char_code_i,
  input  logic               start_of_string_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ADDR_W-1:0]  pixel_address_o,
  output logic [COLOR_W-1:0] pixel_color_o,
  output logic               last_pixel_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [COLOR_W-1:0] cfg_data_i
);

  gtr_state_e state_q, state_d;

  logic [ORG_W-1:0]   origin_x_q, origin_y_q;
  logic [COLOR_W-1:0] fg_q, bg_q;

  logic [IDX_W-1:0]       idx_q;
  logic [CELL_PIXELS-1:0] glyph_q;
  logic [POS_W-1:0]       pos_q;
  logic [CX_W-1:0]        cx_q, last_cx_q;
  logic [CY_W-1:0]        cy_q, last_cy_q;
  logic [ADDR_W-1:0]      addr_q;

  logic               out_valid_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_last_q;

  gtr_cur_cmd_t     cmd;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic             cur_stopped, eff_stopped;

  logic             accept, draw, adv, in_screen, cell_end;
  logic [CODE_W-1:0] subst_code;
  logic [ADDR_W-1:0] addr_step;

  gtr_cursor u_cursor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .origin_x_i   (origin_x_q),
    .origin_y_i   (origin_y_q),
    .col_o        (cur_col),
    .row_o        (cur_row),
    .stopped_o    (cur_stopped),
    .eff_stopped_o(eff_stopped)
  );

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      fg_q       <= '1;
      bg_q       <= '0;
    end else if (cfg_valid_i) begin
      unique case (gtr_cfg_e'(cfg_index_i))
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i[ORG_W-1:0];
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i[ORG_W-1:0];
        CFG_FG_COLOR: fg_q       <= cfg_data_i;
        CFG_BG_COLOR: bg_q       <= cfg_data_i;
      endcase
    end
  end

  // accept and command decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign draw       = accept && !eff_stopped && (char_code_i != CODE_END) &&
                      (char_code_i != CODE_NEWLINE);
  assign subst_code = ((char_code_i < GLYPH_FIRST) || (char_code_i > GLYPH_LAST)) ?
                      GLYPH_SUBST : char_code_i;

  assign adv       = (state_q == ST_WALK) && !(out_valid_q && out_stall_i);
  assign cell_end  = (pos_q == POS_W'(CELL_PIXELS - 1));
  assign in_screen = (cur_col + COL_W'(cx_q) < COL_W'(SCREEN_WIDTH)) &&
                     (HCMP_W'(cur_row) + HCMP_W'(cy_q) < HCMP_W'(SCREEN_HEIGHT));
  assign addr_step = (cy_q == CY_W'(GLYPH_ROWS - 1)) ? STEP_NEXT_COL : STEP_DOWN;

  always_comb begin
    cmd.accept    = accept;
    cmd.start     = start_of_string_i;
    cmd.end_str   = accept && !eff_stopped && (char_code_i == CODE_END);
    cmd.newline   = accept && !eff_stopped && (char_code_i == CODE_NEWLINE);
    cmd.char_done = adv && cell_end;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (draw) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_WALK;
      ST_WALK:  if (adv && cell_end) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // cell datapath: one address add per scanned pixel
  always_ff @(posedge clk_i) begin
    if (draw) begin
      idx_q <= IDX_W'(subst_code - GLYPH_FIRST);
    end
    if (state_q == ST_SETUP) begin
      glyph_q   <= font_cell(idx_q);
      addr_q    <= ADDR_W'(32'(cur_row) * 32'(SCREEN_WIDTH) + 32'(cur_col));
      pos_q     <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      last_cx_q <= (cur_col + COL_W'(GLYPH_COLS) >= COL_W'(SCREEN_WIDTH)) ?
                   CX_W'(COL_W'(SCREEN_WIDTH - 1) - cur_col) : CX_W'(GLYPH_COLS);
      last_cy_q <= (HCMP_W'(cur_row) + HCMP_W'(GLYPH_ROWS - 1) >=
                    HCMP_W'(SCREEN_HEIGHT)) ?
                   CY_W'(HCMP_W'(SCREEN_HEIGHT - 1) - HCMP_W'(cur_row)) :
                   CY_W'(GLYPH_ROWS - 1);
    end else if (adv) begin
      pos_q  <= pos_q + POS_W'(1);
      addr_q <= addr_q + addr_step;
      if (cy_q == CY_W'(GLYPH_ROWS - 1)) begin
        cy_q <= '0;
        cx_q <= cx_q + CX_W'(1);
      end else begin
        cy_q <= cy_q + CY_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_screen;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_screen) begin
      out_addr_q  <= addr_q;
      out_color_q <= glyph_q[pos_q] ? fg_q : bg_q;
      out_last_q  <= (cx_q == last_cx_q) && (cy_q == last_cy_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = out_addr_q;
  assign pixel_color_o   = out_color_q;
  assign last_pixel_o    = out_last_q;

  `GTR_ASSERT_IMPL(a_walk_counters, state_q == ST_WALK,
    (cx_q <= CX_W'(GLYPH_COLS)) && (cy_q <= CY_W'(GLYPH_ROWS - 1)) &&
    (pos_q == POS_W'(cx_q) * POS_W'(GLYPH_ROWS) + POS_W'(cy_q)),
    "scan counters out of step")
  `GTR_ASSERT_IMPL(a_no_draw_when_stopped, state_q != ST_IDLE, !cur_stopped,
    "drawing while stopped")
  `GTR_ASSERT_IMPL(a_last_bound, (state_q == ST_WALK) && in_screen,
    (cx_q <= last_cx_q) && (cy_q <= last_cy_q),
    "visible pixel beyond final pixel position")

endmodule
